/* design/slbm_pkg.sv */
// ----------------------------------------------------------------------------
// slbm_pkg
// Shared types and constants for the serial loaded bank mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package slbm_pkg;

  localparam int unsigned AddrW = 16;
  localparam int unsigned DataW = 8;
  localparam int unsigned InTdataW = 24;
  localparam int unsigned OutTdataW = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 7;

  localparam logic [CfgIdxW-1:0] CfgPrgBanks = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgChrRom = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgWramMode = 2'd2;

  localparam logic [1:0] WramNone = 2'd0;
  localparam logic [1:0] WramFiveWrite = 2'd1;
  localparam logic [1:0] WramFromReg1 = 2'd2;

  localparam logic [1:0] RegControl = 2'd0;
  localparam logic [1:0] RegChrLow = 2'd1;
  localparam logic [1:0] RegChrHigh = 2'd2;
  localparam logic [1:0] RegPrg = 2'd3;

  localparam logic [AddrW-1:0] WramSelAddr = 16'hBFFF;
  localparam logic [4:0] CtrlResetVal = 5'h0C;
  localparam logic [6:0] LargeBankCount = 7'd32;
  localparam logic [2:0] SerialBits = 3'd5;
  localparam logic [2:0] WramWrites = 3'd5;

  localparam logic [6:0] PrgBanksReset = 7'd16;

  typedef struct packed {
    logic [AddrW-1:0] cpu_address;
    logic [DataW-1:0] write_data;
  } item_t;

  typedef struct packed {
    logic [6:0] prg_banks_16k;
    logic       chr_rom_present;
    logic [1:0] wram_mode;
  } cfg_t;

  typedef struct packed {
    logic       wram_page;
    logic [1:0] mirroring;
    logic [4:0] chr_high_bank;
    logic [4:0] chr_low_bank;
    logic [5:0] prg_high_bank;
    logic [5:0] prg_low_bank;
  } map_t;

  localparam map_t MapReset = '{
    wram_page:     1'b0,
    mirroring:     2'd0,
    chr_high_bank: 5'd1,
    chr_low_bank:  5'd0,
    prg_high_bank: 6'd15,
    prg_low_bank:  6'd0
  };

endpackage

`default_nettype wire

/* design/slbm_core.sv */
// ----------------------------------------------------------------------------
// slbm_core
// Serial shifter, mapper registers, five-write WRAM counter and bank map.
// ----------------------------------------------------------------------------
`default_nettype none

module slbm_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  slbm_pkg::item_t item_i,
  input  slbm_pkg::cfg_t  cfg_i,
  output slbm_pkg::map_t  map_d_o
);
  import slbm_pkg::*;

  logic [3:0][4:0] regs_q, regs_d;
  logic [2:0]      shift_cnt_q, shift_cnt_d;
  logic [4:0]      shift_buf_q, shift_buf_d;
  logic [1:0]      last_region_q, last_region_d;
  logic [2:0]      wram_cnt_q, wram_cnt_d;
  logic [2:0]      wram_sum_q, wram_sum_d;
  map_t            map_q, map_d;

  logic       big_cart;
  logic [1:0] region;
  logic       bit_in;
  logic [2:0] cnt0, cnt1, wram_cnt_inc, wram_sum_inc;
  logic [4:0] buf0, buf1, r0, r1, r2, r3;
  logic [5:0] base, prg_lo_32k;
  logic       load;

  always_comb begin
    big_cart = cfg_i.prg_banks_16k >= LargeBankCount;
    region   = item_i.cpu_address[14:13];
    bit_in   = item_i.write_data[0];

    regs_d        = regs_q;
    shift_cnt_d   = shift_cnt_q;
    shift_buf_d   = shift_buf_q;
    last_region_d = last_region_q;
    wram_cnt_d    = wram_cnt_q;
    wram_sum_d    = wram_sum_q;
    map_d         = map_q;

    wram_cnt_inc = wram_cnt_q + 3'd1;
    wram_sum_inc = wram_sum_q + {2'b0, bit_in};
    if (cfg_i.wram_mode == WramFiveWrite && item_i.cpu_address == WramSelAddr) begin
      wram_cnt_d = wram_cnt_inc;
      wram_sum_d = wram_sum_inc;
      if (wram_cnt_inc == WramWrites) begin
        map_d.wram_page = wram_sum_inc != 3'd0;
        wram_cnt_d = 3'd0;
        wram_sum_d = 3'd0;
      end
    end

    cnt0 = shift_cnt_q;
    buf0 = shift_buf_q;
    if (!big_cart) begin
      if (region != last_region_q) begin
        cnt0 = 3'd0;
        buf0 = 5'd0;
      end
      last_region_d = region;
    end

    buf1 = buf0 | (5'({4'b0, bit_in}) << cnt0);
    cnt1 = cnt0 + 3'd1;
    load = 1'b0;

    if (item_i.write_data[7]) begin
      shift_cnt_d = 3'd0;
      shift_buf_d = 5'd0;
      regs_d[RegControl] = regs_q[RegControl] | CtrlResetVal;
    end else if (cnt1 >= SerialBits) begin
      load = 1'b1;
      shift_cnt_d = 3'd0;
      shift_buf_d = 5'd0;
      regs_d[region] = buf1;
    end else begin
      shift_cnt_d = cnt1;
      shift_buf_d = buf1;
    end

    r0 = regs_d[RegControl];
    r1 = regs_d[RegChrLow];
    r2 = regs_d[RegChrHigh];
    r3 = regs_d[RegPrg];
    base = {1'b0, r1[4], 4'b0};
    prg_lo_32k = base + {2'b0, r3[3:1], 1'b0};

    if (load) begin
      if (big_cart) begin
        if (cfg_i.wram_mode == WramFromReg1) map_d.wram_page = r1[4] | r1[3];
        if (region == RegControl) map_d.mirroring = r0[1:0];
        if (cfg_i.chr_rom_present) begin
          map_d.chr_low_bank  = r0[4] ? r1 : {r1[4:1], 1'b0};
          map_d.chr_high_bank = r0[4] ? r2 : {r1[4:1], 1'b1};
        end else if (r0[4]) begin
          map_d.chr_low_bank  = r1;
          map_d.chr_high_bank = r2;
        end
        if (!r0[3]) begin
          map_d.prg_low_bank  = prg_lo_32k;
          map_d.prg_high_bank = prg_lo_32k + 6'd1;
        end else if (r0[2]) begin
          map_d.prg_low_bank  = base + {2'b0, r3[3:0]};
          map_d.prg_high_bank = base + 6'd15;
        end else begin
          map_d.prg_low_bank  = base;
          map_d.prg_high_bank = base + {2'b0, r3[3:0]};
        end
      end else begin
        unique case (region)
          RegControl: map_d.mirroring = r0[1:0];
          RegPrg: begin
            if (!r0[3]) begin
              map_d.prg_low_bank  = {1'b0, r3[4:1], 1'b0};
              map_d.prg_high_bank = {1'b0, r3[4:1], 1'b1};
            end else if (r0[2]) begin
              map_d.prg_low_bank  = {1'b0, r3};
              map_d.prg_high_bank = 6'(cfg_i.prg_banks_16k - 7'd1);
            end else begin
              map_d.prg_low_bank  = 6'd0;
              map_d.prg_high_bank = {1'b0, r3};
            end
          end
          default: begin
            if (cfg_i.chr_rom_present) begin
              map_d.chr_low_bank  = r0[4] ? r1 : {r1[4:1], 1'b0};
              map_d.chr_high_bank = r0[4] ? r2 : {r1[4:1], 1'b1};
            end else if (r0[4]) begin
              map_d.chr_low_bank = regs_d[region];
            end
          end
        endcase
      end
    end
  end

  assign map_d_o = map_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q        <= {5'd0, 5'd0, 5'd0, CtrlResetVal};
      shift_cnt_q   <= 3'd0;
      shift_buf_q   <= 5'd0;
      last_region_q <= 2'd0;
      wram_cnt_q    <= 3'd0;
      wram_sum_q    <= 3'd0;
      map_q         <= MapReset;
    end else if (step_i) begin
      regs_q        <= regs_d;
      shift_cnt_q   <= shift_cnt_d;
      shift_buf_q   <= shift_buf_d;
      last_region_q <= last_region_d;
      wram_cnt_q    <= wram_cnt_d;
      wram_sum_q    <= wram_sum_d;
      map_q         <= map_d;
    end
  end

  a_shift_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    shift_cnt_q < SerialBits)
    else $error("serial shift count out of range");

  a_wram_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wram_cnt_q < WramWrites)
    else $error("WRAM write count out of range");

  a_shift_clear_on_reset_bit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.write_data[7] |=> shift_cnt_q == 3'd0 && shift_buf_q == 5'd0)
    else $error("shifter not cleared by reset-bit write");

endmodule

`default_nettype wire

/* design/serial_loaded_bank_mapper.sv */
// ----------------------------------------------------------------------------
// serial_loaded_bank_mapper
// Serial-loaded bank mapper: one CPU write in, one bank map out.
//
// Each accepted write returns the bank map as it stands after that write. One
// write is accepted per clock while results are taken. An accepted write
// sits in the input register; when it advances, the update logic writes
// the mapper state and the result register together, and the result is then
// offered. While a result waits, the input register takes one more write and
// the input then stalls until the result is taken.
// Configuration registers take effect at the next write and do not refresh
// the current map.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_loaded_bank_mapper (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [slbm_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [slbm_pkg::CfgDataW-1:0]       cfg_wdata_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // cpu_address[15:0], write_data[23:16]
  input  logic [slbm_pkg::InTdataW-1:0]       s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // prg_low_bank[5:0], prg_high_bank[11:6], chr_low_bank[16:12],
  // chr_high_bank[21:17], mirroring[23:22], wram_page[24], zero[31:25]
  output logic [slbm_pkg::OutTdataW-1:0]      m_axis_tdata
);
  import slbm_pkg::*;

  cfg_t  cfg_q;
  item_t in_item_q;
  logic  in_valid_q;
  logic  out_valid_q;
  map_t  out_map_q;
  map_t  map_d;
  logic  step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{prg_banks_16k: PrgBanksReset, chr_rom_present: 1'b1, wram_mode: WramNone};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgPrgBanks: cfg_q.prg_banks_16k   <= cfg_wdata_i;
        CfgChrRom:   cfg_q.chr_rom_present <= cfg_wdata_i[0];
        CfgWramMode: cfg_q.wram_mode       <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (step) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item_q <= '{cpu_address: s_axis_tdata[15:0], write_data: s_axis_tdata[23:16]};
    end
    if (step) out_map_q <= map_d;
  end

  slbm_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .item_i  (in_item_q),
    .cfg_i   (cfg_q),
    .map_d_o (map_d)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutTdataW - $bits(map_t)){1'b0}}, out_map_q};

  a_step_fills_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q)
    else $error("advanced item did not reach the result register");

  a_stall_only_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_valid_q && out_valid_q && !m_axis_tready)
    else $error("input stalled while a stage was free");

endmodule

`default_nettype wire

/* dv/serial_loaded_bank_mapper_test.sv */
// ----------------------------------------------------------------------------
// serial_loaded_bank_mapper_test
// Self-checking bench for the serial loaded bank mapper.
//
// CPU writes go in on the request stream and every accepted write is run
// through a bank-map predictor kept in the bench. Each returned map is
// compared field by field with the oldest prediction. The run covers
// directed corner writes, the five-write WRAM select, a long output stall
// that backs up the input, and random serial loads, reset-bit writes, broken
// sequences and noise under a sweep of bank counts, pattern memory types and
// WRAM modes, with random gaps on both streams.
// ----------------------------------------------------------------------------
module serial_loaded_bank_mapper_test;
  timeunit 1ns;
  timeprecision 1ps;

  import slbm_pkg::*;

  localparam logic [1:0] WramUnused = 2'd3;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned ParkCycles = 300;
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned PhaseItems = 140;
  localparam int unsigned NumPhases = 12;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = CfgPrgBanks;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // cpu_address[15:0], write_data[23:16]
  logic [InTdataW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // prg_low_bank[5:0], prg_high_bank[11:6], chr_low_bank[16:12],
  // chr_high_bank[21:17], mirroring[23:22], wram_page[24], zero[31:25]
  logic [OutTdataW-1:0] m_axis_tdata;

  cfg_t cfg = '{prg_banks_16k: PrgBanksReset, chr_rom_present: 1'b1, wram_mode: WramNone};
  logic [4:0] map_regs [4] = '{CtrlResetVal, 5'd0, 5'd0, 5'd0};
  logic [2:0] shift_cnt = '0;
  logic [4:0] shift_bits = '0;
  logic [1:0] prev_region = '0;
  logic [2:0] wram_writes = '0;
  logic [2:0] wram_ones = '0;
  map_t cur_map = MapReset;
  map_t expected_maps [$];

  int unsigned items_sent = 0;
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;
  int unsigned park_req = 0;
  int unsigned park_ack = 0;
  int unsigned park_left = 0;
  int unsigned stall_left = 0;

  serial_loaded_bank_mapper i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [AddrW-1:0] cpu_addr(input logic [1:0] region);
    if (region == RegChrLow && $urandom_range(0, 9) == 0) return WramSelAddr;
    return {logic'($urandom_range(0, 15) != 0), region, 13'($urandom)};
  endfunction

  function automatic void map_chr_rom(input logic [4:0] ctrl);
    if (ctrl[4]) begin
      cur_map.chr_low_bank = map_regs[RegChrLow];
      cur_map.chr_high_bank = map_regs[RegChrHigh];
    end else begin
      cur_map.chr_low_bank = {map_regs[RegChrLow][4:1], 1'b0};
      cur_map.chr_high_bank = {map_regs[RegChrLow][4:1], 1'b1};
    end
  endfunction

  task automatic apply_cpu_write(input logic [AddrW-1:0] addr, input logic [DataW-1:0] data);
    logic [1:0] region;
    logic big_cart;
    logic [4:0] ctrl;
    logic [4:0] r3;
    logic [5:0] base;
    region = addr[14:13];
    big_cart = cfg.prg_banks_16k >= LargeBankCount;
    if (cfg.wram_mode == WramFiveWrite && addr == WramSelAddr) begin
      wram_writes = wram_writes + 3'd1;
      wram_ones = wram_ones + {2'b0, data[0]};
      if (wram_writes == WramWrites) begin
        cur_map.wram_page = (wram_ones != 3'd0);
        wram_writes = '0;
        wram_ones = '0;
      end
    end
    if (!big_cart) begin
      if (region != prev_region) begin
        shift_cnt = '0;
        shift_bits = '0;
      end
      prev_region = region;
    end
    if (data[7]) begin
      shift_cnt = '0;
      shift_bits = '0;
      map_regs[RegControl] = map_regs[RegControl] | CtrlResetVal;
    end else begin
      if (data[0]) shift_bits[shift_cnt] = 1'b1;
      shift_cnt = shift_cnt + 3'd1;
      if (shift_cnt >= SerialBits) begin
        map_regs[region] = shift_bits;
        shift_bits = '0;
        shift_cnt = '0;
        ctrl = map_regs[RegControl];
        r3 = map_regs[RegPrg];
        if (big_cart) begin
          base = {1'b0, map_regs[RegChrLow][4], 4'd0};
          if (cfg.wram_mode == WramFromReg1) cur_map.wram_page = |map_regs[RegChrLow][4:3];
          if (region == RegControl) cur_map.mirroring = ctrl[1:0];
          if (cfg.chr_rom_present) begin
            map_chr_rom(ctrl);
          end else if (ctrl[4]) begin
            cur_map.chr_low_bank = map_regs[RegChrLow];
            cur_map.chr_high_bank = map_regs[RegChrHigh];
          end
          if (!ctrl[3]) begin
            cur_map.prg_low_bank = base + {2'b0, r3[3:1], 1'b0};
            cur_map.prg_high_bank = cur_map.prg_low_bank + 6'd1;
          end else if (ctrl[2]) begin
            cur_map.prg_low_bank = base + {2'b0, r3[3:0]};
            cur_map.prg_high_bank = base + 6'd15;
          end else begin
            cur_map.prg_low_bank = base;
            cur_map.prg_high_bank = base + {2'b0, r3[3:0]};
          end
        end else if (region == RegControl) begin
          cur_map.mirroring = ctrl[1:0];
        end else if (region == RegPrg) begin
          if (!ctrl[3]) begin
            cur_map.prg_low_bank = {1'b0, r3[4:1], 1'b0};
            cur_map.prg_high_bank = {1'b0, r3[4:1], 1'b1};
          end else if (ctrl[2]) begin
            cur_map.prg_low_bank = {1'b0, r3};
            cur_map.prg_high_bank = 6'(cfg.prg_banks_16k - 7'd1);
          end else begin
            cur_map.prg_low_bank = '0;
            cur_map.prg_high_bank = {1'b0, r3};
          end
        end else if (cfg.chr_rom_present) begin
          map_chr_rom(ctrl);
        end else if (ctrl[4]) begin
          cur_map.chr_low_bank = map_regs[region];
        end
      end
    end
    expected_maps.push_back(cur_map);
  endtask

  task automatic send_write(input logic [AddrW-1:0] addr, input logic [DataW-1:0] data);
    int unsigned gap;
    s_axis_tdata <= {data, addr};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    apply_cpu_write(addr, data);
    items_sent++;
    gap = tx_burst ? 0 : pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic load_reg(input logic [1:0] region, input logic [4:0] value);
    for (int i = 0; i < 5; i++) begin
      send_write(cpu_addr(region), {1'b0, 6'($urandom), value[i]});
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_maps.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
  endtask

  task automatic apply_config(input cfg_t c);
    drain();
    write_cfg(CfgPrgBanks, c.prg_banks_16k);
    write_cfg(CfgChrRom, {6'd0, c.chr_rom_present});
    write_cfg(CfgWramMode, {5'd0, c.wram_mode});
    cfg_we_i <= 1'b0;
    cfg = c;
  endtask

  task automatic random_traffic(input int unsigned count);
    int unsigned stop_at;
    int unsigned pick;
    logic [1:0] region;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      region = 2'($urandom);
      if (pick < 65) begin
        load_reg(region, 5'($urandom));
      end else if (pick < 75) begin
        send_write(cpu_addr(region), {1'b1, 7'($urandom)});
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 4)) send_write(cpu_addr(region), {1'b0, 7'($urandom)});
      end else if (pick < 95) begin
        send_write(16'($urandom), 8'($urandom));
      end else begin
        repeat (5) send_write(WramSelAddr, {1'b0, 7'($urandom)});
      end
    end
  endtask

  task automatic test_directed_edges();
    send_write(16'h8000, 8'h80);
    repeat (5) send_write(16'h8000, 8'h7F);
    for (int i = 0; i < 5; i++) send_write(16'hFFFF, (i % 2 == 0) ? 8'h7F : 8'h00);
    repeat (2) send_write(16'h6000, 8'h01);
    send_write(16'hA000, 8'h00);
    repeat (4) send_write(16'hA000, 8'h01);
    send_write(16'hC000, 8'hFF);
  endtask

  task automatic test_five_write_wram();
    apply_config('{prg_banks_16k: PrgBanksReset, chr_rom_present: 1'b1,
                   wram_mode: WramFiveWrite});
    send_write(WramSelAddr, 8'h01);
    repeat (4) send_write(WramSelAddr, 8'h00);
  endtask

  task automatic test_input_backpressure();
    tx_burst = 1'b1;
    park_req++;
    repeat (8) load_reg(2'($urandom), 5'($urandom));
    tx_burst = 1'b0;
  endtask

  task automatic test_random_configs();
    cfg_t phases [NumPhases];
    phases[0] = '{7'd16, 1'b1, WramNone};
    phases[1] = '{7'd2, 1'b1, WramFiveWrite};
    phases[2] = '{7'd31, 1'b0, WramFromReg1};
    phases[3] = '{7'd32, 1'b1, WramFromReg1};
    phases[4] = '{7'd64, 1'b0, WramFiveWrite};
    phases[5] = '{7'd64, 1'b1, WramFromReg1};
    phases[6] = '{7'd0, 1'b0, WramUnused};
    phases[7] = '{7'd127, 1'b1, WramFiveWrite};
    phases[8] = '{7'd33, 1'b0, WramFromReg1};
    for (int i = 9; i < NumPhases; i++) begin
      phases[i] = '{7'($urandom_range(2, 64)), 1'($urandom), 2'($urandom_range(0, 2))};
    end
    for (int i = 0; i < NumPhases; i++) begin
      apply_config(phases[i]);
      tx_burst = (i % 4 == 3);
      rx_burst = (i % 4 == 1);
      random_traffic(PhaseItems);
    end
    tx_burst = 1'b0;
    rx_burst = 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (park_left != 0) begin
      park_left <= park_left - 1;
      m_axis_tready <= 1'b0;
    end else if (park_req != park_ack) begin
      park_ack <= park_req;
      park_left <= ParkCycles;
      m_axis_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!rx_burst && $urandom_range(0, 99) < 30) begin
      stall_left <= pick_gap();
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    map_t want;
    map_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = map_t'(m_axis_tdata[24:0]);
      if (expected_maps.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
        errors++;
      end else begin
        want = expected_maps.pop_front();
        check_field("prg_low_bank", want.prg_low_bank, got.prg_low_bank);
        check_field("prg_high_bank", want.prg_high_bank, got.prg_high_bank);
        check_field("chr_low_bank", want.chr_low_bank, got.chr_low_bank);
        check_field("chr_high_bank", want.chr_high_bank, got.chr_high_bank);
        check_field("mirroring", want.mirroring, got.mirroring);
        check_field("wram_page", want.wram_page, got.wram_page);
        check_field("padding", 0, m_axis_tdata[31:25]);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_edges();
    test_five_write_wram();
    test_input_backpressure();
    test_random_configs();
    drain();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* files.f */
design/slbm_pkg.sv
design/slbm_core.sv
design/serial_loaded_bank_mapper.sv
dv/serial_loaded_bank_mapper_test.sv
